>>> design/rgb_hsv_converter_8bit_top_defines.svh
// assertion macros for the rgb/hsv converter
`ifndef RGB_HSV_CONVERTER_8BIT_TOP_DEFINES_SVH
`define RGB_HSV_CONVERTER_8BIT_TOP_DEFINES_SVH

// checked on every clock edge outside reset
`define RHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define RHC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/rhc_pkg.sv
// types, constants and helpers shared by the rgb/hsv converter
package rhc_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] hue_in;
    logic [7:0] sat_in;
    logic [7:0] val_in;
  } rhc_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [7:0] hue_out;
    logic [7:0] sat_out;
    logic [7:0] val_out;
  } rhc_out_t;

  // sequencing strobes for the serial units
  typedef struct packed {
    logic load;
    logic step;
  } rhc_seq_t;

  localparam logic CMD_TO_HSV = 1'b0;
  localparam logic CMD_TO_RGB = 1'b1;

  localparam logic [7:0] HUE_SCALE  = 8'd43;
  localparam logic [7:0] HUE_GREEN  = 8'd85;
  localparam logic [7:0] HUE_BLUE   = 8'd171;
  localparam logic [7:0] ROUND_BIAS = 8'd127;
  localparam logic [7:0] F_STEP     = 8'd6;

  // six hue sectors for hsv to rgb
  localparam logic [2:0] HSEC_0 = 3'd0;
  localparam logic [2:0] HSEC_1 = 3'd1;
  localparam logic [2:0] HSEC_2 = 3'd2;
  localparam logic [2:0] HSEC_3 = 3'd3;
  localparam logic [2:0] HSEC_4 = 3'd4;
  localparam logic [2:0] HSEC_5 = 3'd5;

  // hue / 43 by a compare chain
  function automatic logic [2:0] hue_sector(input logic [7:0] h);
    logic [2:0] s;
    if (h >= 8'd215) s = HSEC_5;
    else if (h >= 8'd172) s = HSEC_4;
    else if (h >= 8'd129) s = HSEC_3;
    else if (h >= 8'd86) s = HSEC_2;
    else if (h >= 8'd43) s = HSEC_1;
    else s = HSEC_0;
    return s;
  endfunction

  // (x + 127) >> 8
  function automatic logic [7:0] round_hi(input logic [15:0] x);
    logic [15:0] sum;
    sum = x + {8'h00, ROUND_BIAS};
    return sum[15:8];
  endfunction

endpackage

>>> design/rhc_if.sv
// valid/ready channel interfaces for the rgb/hsv converter
interface rhc_in_if
  import rhc_pkg::*;
();
  logic    valid;
  logic    ready;
  rhc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rhc_out_if
  import rhc_pkg::*;
();
  logic     valid;
  logic     ready;
  rhc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/rhc_sdiv.sv
// bit-serial restoring divider, 16 by 8 with an 8-bit quotient
module rhc_sdiv
  import rhc_pkg::*;
(
  input  logic        clk,
  input  rhc_seq_t    seq,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic [7:0]  quot
);

  logic [7:0] rem;
  logic [7:0] sh;
  logic [7:0] dvsr;
  logic [8:0] trial;
  logic [8:0] diff;
  logic       ge;

  // high byte stays below the divisor, so eight steps give the quotient
  assign trial = {rem, sh[7]};
  assign diff  = trial - {1'b0, dvsr};
  assign ge    = trial >= {1'b0, dvsr};
  assign quot  = sh;

  always_ff @(posedge clk) begin
    if (seq.load) begin
      rem  <= dividend[15:8];
      sh   <= dividend[7:0];
      dvsr <= divisor;
    end else if (seq.step) begin
      rem <= ge ? diff[7:0] : trial[7:0];
      sh  <= {sh[6:0], ge};
    end
  end

endmodule

>>> design/rhc_smul.sv
// bit-serial shift-add multiplier, 8 by 8
module rhc_smul
  import rhc_pkg::*;
(
  input  logic        clk,
  input  rhc_seq_t    seq,
  input  logic [7:0]  a,
  input  logic [7:0]  b,
  output logic [15:0] prod
);

  logic [7:0]  mcand;
  logic [15:0] acc;
  logic [8:0]  sum;

  // low byte holds the multiplier bits still to use
  assign sum  = {1'b0, acc[15:8]} + (acc[0] ? {1'b0, mcand} : 9'd0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (seq.load) begin
      mcand <= a;
      acc   <= {8'h00, b};
    end else if (seq.step) begin
      acc <= {sum, acc[7:1]};
    end
  end

endmodule

>>> design/rgb_hsv_converter_8bit_top.sv
// top level of the two-way 8-bit rgb/hsv converter
//
// usage:
//   in_ch carries one item: cmd picks the direction (rgb to hsv or hsv to rgb),
//   with the rgb channels, the hsv triple and an alpha byte. out_ch returns one
//   result item per input item; fields of the direction not taken read zero.
//   rgb to hsv: two bit-serial 8-bit dividers (saturation and hue) run side by
//   side, one quotient bit a cycle, and a new item is taken only after the
//   result of the last one has left the final state.
//   hsv to rgb: three bit-serial 8x8 multipliers compute s*f, s*(255-f) and
//   v*(255-s) in a first pass of eight steps; two of them then compute the v
//   products in a second pass of eight steps. here too a new item waits.
//   the serial units work eight steps per pass, one bit a step.
//   in_ch.ready is high only while the sequencer is idle.
//   the result sits in an output register; once the work is done the input
//   side opens again even while that result waits for out_ch.ready. a second
//   result waits in the final state until the register is taken.
//   reset (rst, synchronous) empties the output register, returns the
//   sequencer to idle and clears the held hue to zero.
//   the held hue is reported when value or saturation is zero.

`include "rgb_hsv_converter_8bit_top_defines.svh"

module rgb_hsv_converter_8bit_top
  import rhc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  rhc_in_if.sink    in_ch,
  rhc_out_if.source out_ch
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_RUN_A = 3'd2;
  localparam logic [2:0] S_MID   = 3'd3;
  localparam logic [2:0] S_RUN_B = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  // which channel is the maximum
  localparam logic [1:0] MAX_RED   = 2'd0;
  localparam logic [1:0] MAX_GREEN = 2'd1;
  localparam logic [1:0] MAX_BLUE  = 2'd2;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] cnt;

  // captured item
  logic       cmd;
  logic [7:0] alpha;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] hue;
  logic [7:0] sat;
  logic [7:0] val;

  // prepared per-item values
  logic [7:0] max_val;
  logic [1:0] hsec;
  logic       hneg;
  logic [2:0] rsec;

  logic [7:0] held_hue;
  logic       out_valid;
  rhc_out_t   out_data;

  logic accept;
  logic out_free;
  logic running;

  // rgb to hsv preparation
  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  d;
  logic [7:0]  xa;
  logic [7:0]  xb;
  logic [7:0]  mag;
  logic [1:0]  msec;
  logic [15:0] sat_dividend;
  logic [15:0] hue_dividend;
  logic [7:0]  q_sat;
  logic [7:0]  q_hue;

  // hsv to rgb preparation
  logic [2:0]  isec;
  logic [7:0]  rem;
  logic [7:0]  f;
  logic [7:0]  sf;
  logic [7:0]  st;
  logic [7:0]  m0_a;
  logic [7:0]  m0_b;
  logic [7:0]  m1_a;
  logic [7:0]  m1_b;
  logic [15:0] m0_prod;
  logic [15:0] m1_prod;
  logic [15:0] m2_prod;

  rhc_seq_t div_seq;
  rhc_seq_t mpass_seq;
  rhc_seq_t mp_seq;

  // result assembly
  logic [7:0] sat_c;
  logic [7:0] base;
  logic [7:0] hue_c;
  logic       upd;
  logic [7:0] pv;
  logic [7:0] qv;
  logic [7:0] tv;
  logic [7:0] rr;
  logic [7:0] gg;
  logic [7:0] bb;
  rhc_out_t   res;

  assign in_ch.ready  = (state == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign running      = (state == S_RUN_A) || (state == S_RUN_B);

  // ---- rgb to hsv: max, min, sector and dividends ----
  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
    d = mx - mn;
    // red wins ties, then green
    if (red == mx) begin
      msec = MAX_RED;
      xa   = green;
      xb   = blue;
    end else if (green == mx) begin
      msec = MAX_GREEN;
      xa   = blue;
      xb   = red;
    end else begin
      msec = MAX_BLUE;
      xa   = red;
      xb   = green;
    end
    mag          = (xa < xb) ? (xb - xa) : (xa - xb);
    // d*255 as d*256 - d
    sat_dividend = {d, 8'h00} - {8'h00, d};
    hue_dividend = {8'h00, mag} * {8'h00, HUE_SCALE};
  end

  // ---- hsv to rgb: sector, fraction and multiplier operands ----
  always_comb begin
    isec = hue_sector(hue);
    rem  = hue - 8'({5'd0, isec} * HUE_SCALE);
    f    = rem * F_STEP;
    sf   = round_hi(m0_prod);
    st   = round_hi(m1_prod);
    if (state == S_MID) begin
      // second pass: v * (255 - round(s*f)) and v * (255 - round(s*(255-f)))
      m0_a = val;
      m0_b = ~sf;
      m1_a = val;
      m1_b = ~st;
    end else begin
      m0_a = sat;
      m0_b = f;
      m1_a = sat;
      m1_b = ~f;
    end
  end

  assign div_seq   = '{load: (state == S_PREP), step: (state == S_RUN_A)};
  assign mpass_seq = '{load: (state == S_PREP) || (state == S_MID), step: running};
  assign mp_seq    = '{load: (state == S_PREP), step: (state == S_RUN_A)};

  rhc_sdiv u_div_sat (
    .clk      (clk),
    .seq      (div_seq),
    .dividend (sat_dividend),
    .divisor  (mx),
    .quot     (q_sat)
  );

  rhc_sdiv u_div_hue (
    .clk      (clk),
    .seq      (div_seq),
    .dividend (hue_dividend),
    .divisor  (d),
    .quot     (q_hue)
  );

  // q term, then its v product
  rhc_smul u_mul_q (
    .clk  (clk),
    .seq  (mpass_seq),
    .a    (m0_a),
    .b    (m0_b),
    .prod (m0_prod)
  );

  // t term, then its v product
  rhc_smul u_mul_t (
    .clk  (clk),
    .seq  (mpass_seq),
    .a    (m1_a),
    .b    (m1_b),
    .prod (m1_prod)
  );

  // p term: v * (255 - s), first pass only
  rhc_smul u_mul_p (
    .clk  (clk),
    .seq  (mp_seq),
    .a    (val),
    .b    (~sat),
    .prod (m2_prod)
  );

  // ---- result assembly in the final state ----
  always_comb begin
    sat_c = (max_val == 8'd0) ? 8'd0 : q_sat;
    case (hsec)
      MAX_RED:   base = 8'd0;
      MAX_GREEN: base = HUE_GREEN;
      default:   base = HUE_BLUE;
    endcase
    // 8-bit wrap covers the add of 256 for negative hue
    hue_c = hneg ? (base - q_hue) : (base + q_hue);
    upd   = (cmd == CMD_TO_HSV) && (sat_c != 8'd0);

    pv = round_hi(m2_prod);
    qv = round_hi(m0_prod);
    tv = round_hi(m1_prod);
    if (sat == 8'd0) begin
      // grey
      rr = val;
      gg = val;
      bb = val;
    end else begin
      unique case (rsec)
        HSEC_0: begin
          rr = val; gg = tv;  bb = pv;
        end
        HSEC_1: begin
          rr = qv;  gg = val; bb = pv;
        end
        HSEC_2: begin
          rr = pv;  gg = val; bb = tv;
        end
        HSEC_3: begin
          rr = pv;  gg = qv;  bb = val;
        end
        HSEC_4: begin
          rr = tv;  gg = pv;  bb = val;
        end
        default: begin
          rr = val; gg = pv;  bb = qv;
        end
      endcase
    end

    res = '0;
    if (cmd == CMD_TO_RGB) begin
      res.red_out   = rr;
      res.green_out = gg;
      res.blue_out  = bb;
      res.alpha_out = alpha;
    end else begin
      res.hue_out = upd ? hue_c : held_hue;
      res.sat_out = sat_c;
      res.val_out = max_val;
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = S_RUN_A;
      end
      S_RUN_A: begin
        if (cnt == 3'd7) state_next = (cmd == CMD_TO_RGB) ? S_MID : S_FIN;
      end
      S_MID: begin
        state_next = S_RUN_B;
      end
      S_RUN_B: begin
        if (cnt == 3'd7) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 3'd0;
      out_valid <= 1'b0;
      held_hue  <= 8'd0;
    end else begin
      state <= state_next;
      cnt   <= running ? (cnt + 3'd1) : 3'd0;
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
        if (upd) held_hue <= hue_c;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= in_ch.data.cmd;
      alpha <= in_ch.data.alpha;
      red   <= in_ch.data.red;
      green <= in_ch.data.green;
      blue  <= in_ch.data.blue;
      hue   <= in_ch.data.hue_in;
      sat   <= in_ch.data.sat_in;
      val   <= in_ch.data.val_in;
    end
    if (state == S_PREP) begin
      max_val <= mx;
      hsec    <= msec;
      hneg    <= (xa < xb);
      rsec    <= isec;
    end
    if ((state == S_FIN) && out_free) begin
      out_data <= res;
    end
  end

  // ---- checks ----
  `RHC_ASSERT(a_accept_starts, accept |=> (state == S_PREP), "accepted item did not start work")
  `RHC_ASSERT(a_cnt_in_run, (cnt != 3'd0) |-> running, "step counter live outside a run pass")
  `RHC_ASSERT(a_result_from_fin, $rose(out_ch.valid) |-> ($past(state) == S_FIN), "result not from final state")
  `RHC_ASSERT(a_hue_update, (!$past(rst) && (held_hue != $past(held_hue))) |-> (($past(state) == S_FIN) && ($past(cmd) == CMD_TO_HSV)), "held hue changed outside rgb result")
  `RHC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_ch.valid, "output valid after reset")

endmodule

>>> sim/testbench.sv
// self-checking testbench for the two-way 8-bit rgb/hsv converter
module testbench
  import rhc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1200;
  // worst case is the busy time plus a long gap on each side per item
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned PRINT_CAP    = 40;

  // one row of the directed table; want is used only when fixed is set
  typedef struct packed {
    rhc_in_t  item;
    logic     fixed;
    rhc_out_t want;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhc_in_if  in_ch ();
  rhc_out_if out_ch ();

  rgb_hsv_converter_8bit_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // model state: the hue reported when value or saturation is zero
  logic [7:0] held_hue = 8'd0;

  rhc_out_t    pending_colors [$];
  logic        row_fixed = 1'b0;
  rhc_out_t    row_want  = '0;
  bit          quiet     = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;
  int unsigned n_to_hsv    = 0;
  int unsigned n_to_rgb    = 0;
  int unsigned n_held      = 0;
  int unsigned n_results   = 0;

  // fields: cmd, alpha, red, green, blue, hue_in, sat_in, val_in
  // want:   red_out, green_out, blue_out, alpha_out, hue_out, sat_out, val_out
  dir_row_t dir_table [DIR_ROWS] = '{
    // black right after reset reports the reset hue
    '{'{CMD_TO_HSV, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
    // white: grey at full value
    '{'{CMD_TO_HSV, 0, 255, 255, 255, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 255}},
    // primaries land on the sector starts
    '{'{CMD_TO_HSV, 0, 255, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 255, 255}},
    '{'{CMD_TO_HSV, 0, 0, 255, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 85, 255, 255}},
    '{'{CMD_TO_HSV, 0, 0, 0, 255, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 171, 255, 255}},
    // grey and black keep the blue hue
    '{'{CMD_TO_HSV, 0, 77, 77, 77, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 171, 0, 77}},
    '{'{CMD_TO_HSV, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 171, 0, 0}},
    // negative hue wraps, red wins ties with blue, single-step spread
    '{'{CMD_TO_HSV, 0, 255, 0, 128, 0, 0, 0}, 1'b0, '0},
    '{'{CMD_TO_HSV, 0, 255, 0, 255, 0, 0, 0}, 1'b0, '0},
    '{'{CMD_TO_HSV, 0, 255, 254, 254, 0, 0, 0}, 1'b0, '0},
    '{'{CMD_TO_HSV, 0, 0, 1, 1, 0, 0, 0}, 1'b0, '0},
    '{'{CMD_TO_HSV, 0, 200, 100, 50, 0, 0, 0}, 1'b0, '0},
    // zero saturation gives grey, alpha passes through
    '{'{CMD_TO_RGB, 165, 0, 0, 0, 123, 0, 200}, 1'b1, '{200, 200, 200, 165, 0, 0, 0}},
    '{'{CMD_TO_RGB, 0, 0, 0, 0, 255, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 0}},
    // hue sectors 0, 1, 2, 3 and 5 at full saturation and value
    '{'{CMD_TO_RGB, 255, 0, 0, 0, 0, 255, 255}, 1'b0, '0},
    '{'{CMD_TO_RGB, 17, 0, 0, 0, 43, 255, 255}, 1'b0, '0},
    '{'{CMD_TO_RGB, 34, 0, 0, 0, 86, 255, 255}, 1'b0, '0},
    '{'{CMD_TO_RGB, 68, 0, 0, 0, 129, 255, 255}, 1'b0, '0},
    '{'{CMD_TO_RGB, 136, 0, 0, 0, 215, 255, 255}, 1'b0, '0},
    // last sector with f at its top, and f at its top in sector 0
    '{'{CMD_TO_RGB, 1, 0, 0, 0, 255, 255, 255}, 1'b0, '0},
    '{'{CMD_TO_RGB, 128, 0, 0, 0, 42, 200, 180}, 1'b0, '0},
    // zero value is black whatever the hue
    '{'{CMD_TO_RGB, 90, 0, 0, 0, 42, 255, 0}, 1'b1, '{0, 0, 0, 90, 0, 0, 0}},
    // hsv to rgb must leave the held hue alone
    '{'{CMD_TO_HSV, 0, 10, 10, 10, 0, 0, 0}, 1'b0, '0},
    '{'{CMD_TO_HSV, 0, 0, 255, 255, 0, 0, 0}, 1'b0, '0},
    '{'{CMD_TO_RGB, 0, 0, 0, 0, 128, 1, 255}, 1'b0, '0}
  };

  // expected color for one item; rgb to hsv updates the held hue
  function automatic rhc_out_t convert_color(input rhc_in_t it);
    rhc_out_t    res;
    int unsigned r, g, b, mx, mn, d, sat, qm;
    int unsigned hh, s, v, i, f, p, q, t;
    int unsigned scale, fstep, bias;
    int          num, base, h;
    res   = '0;
    scale = 32'(HUE_SCALE);
    fstep = 32'(F_STEP);
    bias  = 32'(ROUND_BIAS);
    if (it.cmd == CMD_TO_HSV) begin
      r = 32'(it.red);
      g = 32'(it.green);
      b = 32'(it.blue);
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      d = mx - mn;
      sat = 0;
      if (mx != 0) sat = (d * 255) / mx;
      if (sat != 0) begin
        // red wins ties, then green
        if (r == mx) begin
          base = 0;
          num = int'(g) - int'(b);
        end else if (g == mx) begin
          base = int'(HUE_GREEN);
          num = int'(b) - int'(r);
        end else begin
          base = int'(HUE_BLUE);
          num = int'(r) - int'(g);
        end
        // quotient truncates toward zero, so work on the magnitude
        if (num < 0) begin
          qm = (scale * unsigned'(-num)) / d;
          h = base - int'(qm);
        end else begin
          qm = (scale * unsigned'(num)) / d;
          h = base + int'(qm);
        end
        if (h < 0) h = h + 256;
        held_hue = h[7:0];
      end else begin
        n_held++;
      end
      res.hue_out = held_hue;
      res.sat_out = sat[7:0];
      res.val_out = mx[7:0];
    end else begin
      hh = 32'(it.hue_in);
      s = 32'(it.sat_in);
      v = 32'(it.val_in);
      if (s == 0) begin
        r = v;
        g = v;
        b = v;
      end else begin
        i = hh / scale;
        f = (hh - i * scale) * fstep;
        p = (v * (255 - s) + bias) >> 8;
        q = (v * (255 - ((s * f + bias) >> 8)) + bias) >> 8;
        t = (v * (255 - ((s * (255 - f) + bias) >> 8)) + bias) >> 8;
        case (i[2:0])
          HSEC_0: begin r = v; g = t; b = p; end
          HSEC_1: begin r = q; g = v; b = p; end
          HSEC_2: begin r = p; g = v; b = t; end
          HSEC_3: begin r = p; g = q; b = v; end
          HSEC_4: begin r = t; g = p; b = v; end
          default: begin r = v; g = p; b = q; end
        endcase
      end
      res.red_out   = r[7:0];
      res.green_out = g[7:0];
      res.blue_out  = b[7:0];
      res.alpha_out = it.alpha;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random item shaped toward the corners of both conversions
  function automatic rhc_in_t random_item();
    rhc_in_t     it;
    int unsigned pick;
    it.cmd    = 1'($urandom_range(0, 1));
    it.alpha  = 8'($urandom_range(0, 255));
    it.red    = 8'($urandom_range(0, 255));
    it.green  = 8'($urandom_range(0, 255));
    it.blue   = 8'($urandom_range(0, 255));
    it.hue_in = 8'($urandom_range(0, 255));
    it.sat_in = 8'($urandom_range(0, 255));
    it.val_in = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (it.cmd == CMD_TO_HSV) begin
      if (pick < 6) begin
        // grey
        it.green = it.red;
        it.blue  = it.red;
      end else if (pick < 9) begin
        it.red   = 8'd0;
        it.green = 8'd0;
        it.blue  = 8'd0;
      end else if (pick < 22) begin
        // two equal channels exercise the max priority
        case ($urandom_range(0, 2))
          0: it.green = it.red;
          1: it.blue = it.green;
          default: it.blue = it.red;
        endcase
      end else if (pick < 35) begin
        // tiny values: small divisors
        it.red   = 8'($urandom_range(0, 3));
        it.green = 8'($urandom_range(0, 3));
        it.blue  = 8'($urandom_range(0, 3));
      end else if (pick < 45) begin
        // one channel at full scale, another at zero
        case ($urandom_range(0, 2))
          0: begin it.red = 8'd255; it.blue = 8'd0; end
          1: begin it.green = 8'd255; it.red = 8'd0; end
          default: begin it.blue = 8'd255; it.green = 8'd0; end
        endcase
      end
    end else begin
      if (pick < 10) begin
        it.sat_in = 8'd0;
      end else if (pick < 30) begin
        // sector edges
        case ($urandom_range(0, 11))
          0: it.hue_in = 8'd0;
          1: it.hue_in = 8'd42;
          2: it.hue_in = 8'd43;
          3: it.hue_in = 8'd85;
          4: it.hue_in = 8'd86;
          5: it.hue_in = 8'd128;
          6: it.hue_in = 8'd129;
          7: it.hue_in = 8'd171;
          8: it.hue_in = 8'd172;
          9: it.hue_in = 8'd214;
          10: it.hue_in = 8'd215;
          default: it.hue_in = 8'd255;
        endcase
      end else if (pick < 40) begin
        it.sat_in = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd1;
        it.val_in = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      end
    end
    return it;
  endfunction

  // present one item at a falling edge and hold it until it is taken
  task automatic send_item(input rhc_in_t it, input logic fixed, input rhc_out_t want);
    int unsigned gap;
    gap = gap_len();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    row_fixed   <= fixed;
    row_want    <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_colors.size());
      $display("tb: failure");
      $finish;
    end
  end

  // scoreboard: results are checked before new items are queued
  always @(posedge clk) begin : scoreboard
    rhc_out_t want;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_colors.size() == 0) begin
          report_mismatch($sformatf("result %h with none expected", out_ch.data));
        end else begin
          want = pending_colors.pop_front();
          check_field("red_out", out_ch.data.red_out, want.red_out);
          check_field("green_out", out_ch.data.green_out, want.green_out);
          check_field("blue_out", out_ch.data.blue_out, want.blue_out);
          check_field("alpha_out", out_ch.data.alpha_out, want.alpha_out);
          check_field("hue_out", out_ch.data.hue_out, want.hue_out);
          check_field("sat_out", out_ch.data.sat_out, want.sat_out);
          check_field("val_out", out_ch.data.val_out, want.val_out);
          n_results++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        // predictor always runs so the held hue tracks every item
        want = convert_color(in_ch.data);
        if (row_fixed) want = row_want;
        pending_colors.push_back(want);
        if (in_ch.data.cmd == CMD_TO_HSV) n_to_hsv++;
        else n_to_rgb++;
      end
    end
  end

  // result side: ready in random stretches, held high in quiet phases
  initial begin : result_sink
    int unsigned hold;
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (quiet) hold = 40;
      else if ($urandom_range(0, 99) < 80) hold = $urandom_range(1, 4);
      else hold = $urandom_range(10, 30);
      out_ch.ready <= 1'b1;
      repeat (hold) @(negedge clk);
      stall = gap_len();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned k;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_ROWS; k++) begin
      send_item(dir_table[k].item, dir_table[k].fixed, dir_table[k].want);
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // two stretches with no idling on either side
      quiet = (k >= 300 && k < 400) || (k >= 900 && k < 960);
      send_item(random_item(), 1'b0, '0);
    end
    quiet = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending_colors.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d rgb to hsv items (%0d with held hue) and %0d hsv to rgb items",
             n_to_hsv, n_held, n_to_rgb);
    $display("%0d results checked, %0d mismatches", n_results, err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/rhc_pkg.sv
design/rhc_if.sv
design/rhc_sdiv.sv
design/rhc_smul.sv
design/rgb_hsv_converter_8bit_top.sv
sim/testbench.sv
